[src/button_and_key_input_events_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the button and key input event block
// Concurrent checks on clk, disabled while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AND_KEY_INPUT_EVENTS_ASSERT_SVH
`define BUTTON_AND_KEY_INPUT_EVENTS_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BKE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_and_key_input_events: implication check failed");

// Next-cycle implication.
`define BKE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_and_key_input_events: next-cycle check failed");

// Condition that must never hold.
`define BKE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("button_and_key_input_events: forbidden condition seen");

`else

`define BKE_ASSERT_IMPLY(lbl, ante, cons)
`define BKE_ASSERT_NEXT(lbl, ante, cons)
`define BKE_ASSERT_NEVER(lbl, cond)

`endif

`endif

[src/bke_pkg.sv]
// ----------------------------------------------------------------------------
// bke_pkg
// Shared types and constants for the button and key input event block.
// ----------------------------------------------------------------------------
`default_nettype none

package bke_pkg;

  // Configuration register widths and reset values
  localparam int DEB_W   = 20;
  localparam int LONG_W  = 24;
  localparam int STUCK_W = 26;
  localparam int WIN_W   = 30;
  localparam int THR_W   = 26;  // widest of the three hold thresholds
  localparam int CFG_W   = 30;  // config write data width

  localparam logic [DEB_W-1:0]   DEB_RESET   = 20'd30000;
  localparam logic [LONG_W-1:0]  LONG_RESET  = 24'd600000;
  localparam logic [STUCK_W-1:0] STUCK_RESET = 26'd5000000;
  localparam logic [WIN_W-1:0]   WIN_RESET   = 30'd30000000;

  // Register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG     = 2'd1;
  localparam logic [1:0] CFG_STUCK    = 2'd2;
  localparam logic [1:0] CFG_WINDOW   = 2'd3;

  // Item opcodes
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_KEY    = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BTN_DOWN = 3'd1,
    EV_SHORT    = 3'd2,
    EV_LONG     = 3'd3,
    EV_KEY      = 3'd4
  } event_code_t;

  typedef enum logic [3:0] {
    KK_NONE      = 4'd0,
    KK_CHAR      = 4'd1,
    KK_BACKSPACE = 4'd2,
    KK_TAB       = 4'd3,
    KK_ENTER     = 4'd4,
    KK_ESC       = 4'd5,
    KK_LEFT      = 4'd6,
    KK_UP        = 4'd7,
    KK_DOWN      = 4'd8,
    KK_RIGHT     = 4'd9
  } key_kind_t;

  // Raw key byte codes
  localparam logic [7:0] KB_PRINT_LO  = 8'h20;
  localparam logic [7:0] KB_PRINT_HI  = 8'h7E;
  localparam logic [7:0] KB_BACKSPACE = 8'h08;
  localparam logic [7:0] KB_TAB       = 8'h09;
  localparam logic [7:0] KB_ENTER     = 8'h0D;
  localparam logic [7:0] KB_ESC       = 8'h1B;
  localparam logic [7:0] KB_LEFT      = 8'hB4;
  localparam logic [7:0] KB_UP        = 8'hB5;
  localparam logic [7:0] KB_DOWN      = 8'hB6;
  localparam logic [7:0] KB_RIGHT     = 8'hB7;

  typedef struct packed {
    key_kind_t  kind;
    logic [6:0] chr;
  } key_dec_t;

endpackage

`default_nettype wire

[src/bke_key_decode.sv]
// ----------------------------------------------------------------------------
// bke_key_decode
// Maps a raw keyboard byte to a printable character or a control key.
// ----------------------------------------------------------------------------
`default_nettype none

module bke_key_decode
  import bke_pkg::*;
(
  input  wire logic [7:0] key_byte,
  output key_dec_t        dec
);

  always_comb begin
    dec.kind = KK_NONE;
    dec.chr  = 7'd0;
    if (key_byte >= KB_PRINT_LO && key_byte <= KB_PRINT_HI) begin
      dec.kind = KK_CHAR;
      dec.chr  = key_byte[6:0];
    end else begin
      case (key_byte)
        KB_BACKSPACE: dec.kind = KK_BACKSPACE;
        KB_TAB:       dec.kind = KK_TAB;
        KB_ENTER:     dec.kind = KK_ENTER;
        KB_ESC:       dec.kind = KK_ESC;
        KB_LEFT:      dec.kind = KK_LEFT;
        KB_UP:        dec.kind = KK_UP;
        KB_DOWN:      dec.kind = KK_DOWN;
        KB_RIGHT:     dec.kind = KK_RIGHT;
        default:      dec.kind = KK_NONE;  // drop everything else
      endcase
    end
  end

endmodule

`default_nettype wire

[src/button_and_key_input_events.sv]
// ----------------------------------------------------------------------------
// button_and_key_input_events
// Button debounce with short/long/stuck press detection, keyboard byte
// decoding and an awake window, one result per request.
// ----------------------------------------------------------------------------
// Every request carries a time stamp (now_us, non-decreasing) and either a
// sample of the active-low button pin or a raw keyboard byte, and yields
// exactly one result. The button machine runs idle -> down -> held -> stuck:
// a low level seen twice, the second time at least debounce_time_us after
// the first, reports button down; release before long_press_time_us reports
// a short press, and the first low sample at or past that time reports a long
// press; staying low stuck_time_us longer sets the stuck flag, and release
// from held or stuck returns to idle silently. Printable bytes 0x20..0x7E and
// eight control keys report a key event; other bytes give event none. Each
// reported event re-arms the awake deadline to now_us + awake_window_us.
// The block takes one request per clock when the result side keeps up:
// a request waits in the input register, where the step is computed, and
// is then held in the result register until taken, so results come out in
// order. Configuration writes are accepted in any cycle (cfg_ready is always
// high) and must be issued only while no request is in flight. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_and_key_input_events_assert.svh"

module button_and_key_input_events
  import bke_pkg::*;
#(
  parameter int TIME_WIDTH = 48
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  // Configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,

  // Request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  opcode,
  input  wire logic                  button_level,
  input  wire logic [7:0]            key_byte,
  input  wire logic [TIME_WIDTH-1:0] now_us,

  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 event_code,
  output logic [3:0]                 key_kind,
  output logic [6:0]                 key_char,
  output logic                       awake,
  output logic                       button_busy,
  output logic                       button_stuck
);

  localparam int DL_W = TIME_WIDTH + 1;  // deadline never wraps

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DOWN,
    PH_HELD,
    PH_STUCK
  } phase_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DEB_W-1:0]   debounce_time;
  logic [LONG_W-1:0]  long_time;
  logic [STUCK_W-1:0] stuck_time;
  logic [WIN_W-1:0]   awake_window;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEB_RESET;
      long_time     <= LONG_RESET;
      stuck_time    <= STUCK_RESET;
      awake_window  <= WIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_time <= cfg_data[DEB_W-1:0];
        CFG_LONG:     long_time     <= cfg_data[LONG_W-1:0];
        CFG_STUCK:    stuck_time    <= cfg_data[STUCK_W-1:0];
        CFG_WINDOW:   awake_window  <= cfg_data[WIN_W-1:0];
        default:      ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register feeds the result register
  // --------------------------------------------------------------------------
  logic                  s1_valid;
  logic                  s1_opcode;
  logic                  s1_level;
  logic [7:0]            s1_byte;
  logic [TIME_WIDTH-1:0] s1_now;

  logic out_load;  // result register free this cycle
  logic s1_fire;   // step the state with the held request

  assign out_load = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  // --------------------------------------------------------------------------
  // Machine state
  // --------------------------------------------------------------------------
  phase_t                phase;
  logic                  debounce_pending;
  logic [TIME_WIDTH-1:0] debounce_start;
  logic [TIME_WIDTH-1:0] press_start;
  logic [TIME_WIDTH-1:0] held_start;
  logic [DL_W-1:0]       awake_deadline;

  // Key decode of the held byte
  key_dec_t key_dec;

  bke_key_decode u_key_decode (
    .key_byte (s1_byte),
    .dec      (key_dec)
  );

  // --------------------------------------------------------------------------
  // Step logic
  // --------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] cmp_start;
  logic [THR_W-1:0]      cmp_thr;
  logic [DL_W-1:0]       cmp_diff;
  logic                  timed_out;

  phase_t                phase_next;
  logic                  debounce_pending_next;
  logic                  set_debounce_start;
  logic                  set_press_start;
  logic                  set_held_start;
  logic                  arm;
  event_code_t           ev;
  logic [DL_W-1:0]       awake_deadline_next;
  logic                  awake_next;

  // Only one timer matters per phase: pick its start and threshold
  always_comb begin
    case (phase)
      PH_IDLE: begin
        cmp_start = debounce_start;
        cmp_thr   = THR_W'(debounce_time);
      end
      PH_DOWN: begin
        cmp_start = press_start;
        cmp_thr   = THR_W'(long_time);
      end
      PH_HELD: begin
        cmp_start = held_start;
        cmp_thr   = THR_W'(stuck_time);
      end
      default: begin
        cmp_start = held_start;
        cmp_thr   = THR_W'(stuck_time);
      end
    endcase
  end

  // Elapsed time counts as zero when the clock appears to run backwards
  assign cmp_diff  = {1'b0, s1_now} - {1'b0, cmp_start};
  assign timed_out = cmp_diff[TIME_WIDTH] ? (cmp_thr == '0)
                                          : (cmp_diff[TIME_WIDTH-1:0] >=
                                             TIME_WIDTH'(cmp_thr));

  always_comb begin
    phase_next            = phase;
    debounce_pending_next = debounce_pending;
    set_debounce_start    = 1'b0;
    set_press_start       = 1'b0;
    set_held_start        = 1'b0;
    arm                   = 1'b0;
    ev                    = EV_NONE;

    if (s1_opcode == OP_KEY) begin
      // Keys never step the button machine
      if (key_dec.kind != KK_NONE) begin
        arm = 1'b1;
        ev  = EV_KEY;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (!s1_level) begin
            if (!debounce_pending) begin
              debounce_pending_next = 1'b1;
              set_debounce_start    = 1'b1;
            end else if (timed_out) begin
              phase_next            = PH_DOWN;
              debounce_pending_next = 1'b0;
              set_press_start       = 1'b1;
              arm                   = 1'b1;
              ev                    = EV_BTN_DOWN;
            end
          end else begin
            debounce_pending_next = 1'b0;
          end
        end
        PH_DOWN: begin
          if (s1_level) begin
            phase_next = PH_IDLE;
            arm        = 1'b1;
            ev         = EV_SHORT;
          end else if (timed_out) begin
            phase_next     = PH_HELD;
            set_held_start = 1'b1;
            arm            = 1'b1;
            ev             = EV_LONG;
          end
        end
        PH_HELD: begin
          if (s1_level) begin
            phase_next = PH_IDLE;
          end else if (timed_out) begin
            phase_next = PH_STUCK;
          end
        end
        default: begin
          if (s1_level) begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  assign awake_deadline_next = arm ? ({1'b0, s1_now} + DL_W'(awake_window))
                                   : awake_deadline;
  assign awake_next = {1'b0, s1_now} < awake_deadline_next;

  // --------------------------------------------------------------------------
  // State, input register and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      phase            <= PH_IDLE;
      debounce_pending <= 1'b0;
      awake_deadline   <= '0;
    end else begin
      // Input register: load on accept, drop once stepped
      if (in_valid && in_ready) begin
        s1_valid  <= 1'b1;
        s1_opcode <= opcode;
        s1_level  <= button_level;
        s1_byte   <= key_byte;
        s1_now    <= now_us;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= s1_valid;
      end

      if (s1_fire) begin
        phase            <= phase_next;
        debounce_pending <= debounce_pending_next;
        awake_deadline   <= awake_deadline_next;
        if (set_debounce_start) begin
          debounce_start <= s1_now;
        end
        if (set_press_start) begin
          press_start <= s1_now;
        end
        if (set_held_start) begin
          held_start <= s1_now;
        end

        // Result reflects the state after this step
        event_code   <= ev;
        key_kind     <= (s1_opcode == OP_KEY) ? key_dec.kind : KK_NONE;
        key_char     <= (s1_opcode == OP_KEY) ? key_dec.chr : 7'd0;
        awake        <= awake_next;
        button_busy  <= (phase_next == PH_DOWN) || (phase_next == PH_HELD);
        button_stuck <= (phase_next == PH_STUCK);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BKE_ASSERT_NEVER(a_busy_and_stuck, out_valid && button_busy && button_stuck)
  `BKE_ASSERT_NEVER(a_pending_outside_idle, debounce_pending && (phase != PH_IDLE))
  `BKE_ASSERT_NEXT(a_stuck_only_from_held, (phase == PH_IDLE) || (phase == PH_DOWN), phase != PH_STUCK)
  `BKE_ASSERT_IMPLY(a_key_kind_matches_event, out_valid, (event_code == EV_KEY) == (key_kind != KK_NONE))

endmodule

`default_nettype wire
